// ----- rtl/mtep_pkg.sv -----
// Shared types and constants for the MIDI track event parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtep_pkg;

    // Longest delta-time quantity, in bytes
    localparam logic [2:0] MAX_DELTA_BYTES = 3'd4;

    // Status and meta type codes
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] ST_CHAN_LO   = 8'h80;
    localparam logic [7:0] ST_CHAN_HI   = 8'hEF;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;

    // Event kinds
    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_SYSEX   = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_TEMPO   = 3'd3;
    localparam logic [2:0] KIND_TIMESIG = 3'd4;
    localparam logic [2:0] KIND_EOT     = 3'd5;

    // Channel message types that matter to the parser
    localparam logic [2:0] MSG_PROGRAM    = 3'd4;
    localparam logic [2:0] MSG_CHAN_PRESS = 3'd5;
    localparam logic [2:0] MSG_BEND       = 3'd6;

    // Request held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] track_byte;
        logic       track_start;
    } t_in_item;

    // One event record
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [27:0] delta_ticks;
        logic [2:0]  message_type;
        logic [3:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [13:0] bend_value;
        logic [23:0] tempo_us;
        logic [7:0]  payload_length;
        logic [7:0]  clocks_per_click;
        logic [7:0]  thirtyseconds_per_quarter;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/mtep_in_reg.sv -----
// Input register of the MIDI track event parser.
// Holds one accepted byte request until the parser takes it; uses mtep_pkg.
`default_nettype none

module mtep_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_track_byte,
    input  wire logic              i_track_start,
    output logic                   o_stall,
    input  wire logic              i_take,
    output mtep_pkg::t_in_item     o_item
);
    import mtep_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;

    // Stall only while a held request is not consumed this cycle
    assign o_stall = r_valid && !i_take;

    // Load a new request or drop the consumed one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the request payload on acceptance
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_track_byte;
            r_start <= i_track_start;
        end
    end

    assign o_item = '{valid: r_valid, track_byte: r_byte, track_start: r_start};

endmodule

`default_nettype wire

// ----- rtl/mtep_parser.sv -----
// Parse state machine and result register of the MIDI track event parser.
// Consumes a byte per cycle from mtep_in_reg unless stalled; uses mtep_pkg.
`default_nettype none

module mtep_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtep_pkg::t_in_item i_item,
    output logic                   o_take,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output mtep_pkg::t_result      o_result
);
    import mtep_pkg::*;

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
        PH_METATYPE, PH_LEN, PH_SKIP, PH_DONE
    } t_phase;

    t_phase      r_phase, cur_phase, n_phase;
    logic [27:0] r_delta, cur_delta, n_delta;
    logic [2:0]  r_cnt, cur_cnt, n_cnt;
    logic [7:0]  r_status, cur_status, n_status;
    logic [7:0]  r_hold [4];
    logic [7:0]  cur_hold [4];
    logic [7:0]  n_hold [4];
    logic [7:0]  r_skip, cur_skip, n_skip;
    logic [7:0]  r_meta, cur_meta, n_meta;
    logic [23:0] r_tempo, cur_tempo, n_tempo;
    logic [7:0]  r_len, cur_len, n_len;
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        emit_chan, emit_long, emit;
    logic [7:0]  b;
    logic [2:0]  msg_t;
    logic [7:0]  idx;
    logic        advance;

    assign b = i_item.track_byte;

    // Track start clears the parse state before the byte is used
    always_comb begin
        if (i_item.track_start) begin
            cur_phase  = PH_DELTA;
            cur_delta  = '0;
            cur_cnt    = '0;
            cur_status = '0;
            cur_skip   = '0;
            cur_meta   = '0;
            cur_tempo  = '0;
            cur_len    = '0;
            for (int k = 0; k < 4; k++) cur_hold[k] = '0;
        end else begin
            cur_phase  = r_phase;
            cur_delta  = r_delta;
            cur_cnt    = r_cnt;
            cur_status = r_status;
            cur_skip   = r_skip;
            cur_meta   = r_meta;
            cur_tempo  = r_tempo;
            cur_len    = r_len;
            for (int k = 0; k < 4; k++) cur_hold[k] = r_hold[k];
        end
    end

    assign msg_t = cur_status[6:4];
    assign idx   = cur_len - cur_skip;

    // Next state for one byte
    always_comb begin
        n_phase   = cur_phase;
        n_delta   = cur_delta;
        n_cnt     = cur_cnt;
        n_status  = cur_status;
        n_skip    = cur_skip;
        n_meta    = cur_meta;
        n_tempo   = cur_tempo;
        n_len     = cur_len;
        for (int k = 0; k < 4; k++) n_hold[k] = cur_hold[k];
        emit_chan = 1'b0;
        emit_long = 1'b0;

        unique case (cur_phase)
            PH_DELTA: begin
                n_delta = {cur_delta[20:0], b[6:0]};
                n_cnt   = cur_cnt + 3'd1;
                if (!b[7] || n_cnt >= MAX_DELTA_BYTES) begin
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                for (int k = 0; k < 4; k++) n_hold[k] = '0;
                n_tempo = '0;
                n_meta  = '0;
                n_len   = '0;
                n_skip  = '0;
                priority if (b >= ST_CHAN_LO && b <= ST_CHAN_HI) begin
                    n_status = b;
                    n_phase  = PH_DATA1;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    n_status = b;
                    n_phase  = PH_LEN;
                end else if (b == ST_META) begin
                    n_status = b;
                    n_phase  = PH_METATYPE;
                end else begin
                    // Drop a bad status byte and restart the delta time
                    n_delta = '0;
                    n_cnt   = '0;
                    n_phase = PH_DELTA;
                end
            end
            PH_DATA1: begin
                n_hold[0] = b;
                if (msg_t == MSG_PROGRAM || msg_t == MSG_CHAN_PRESS) begin
                    emit_chan = 1'b1;
                end else begin
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                n_hold[1] = b;
                emit_chan = 1'b1;
            end
            PH_METATYPE: begin
                n_meta  = b;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len  = b;
                n_skip = b;
                if (b == 8'd0) begin
                    emit_long = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                // Capture tempo and time signature payload bytes
                if (cur_status == ST_META && cur_meta == META_TEMPO && idx < 8'd3) begin
                    n_tempo = {cur_tempo[15:0], b};
                end
                if (cur_status == ST_META && cur_meta == META_TIMESIG && idx < 8'd4) begin
                    n_hold[idx[1:0]] = b;
                end
                n_skip = cur_skip - 8'd1;
                if (n_skip == 8'd0) begin
                    emit_long = 1'b1;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DELTA;
            end
        endcase

        // Build the record from the updated state
        n_res = '0;
        n_res.delta_ticks = cur_delta;
        if (emit_chan) begin
            n_res.event_kind   = KIND_CHANNEL;
            n_res.message_type = msg_t;
            n_res.channel      = n_status[3:0];
            n_res.first_data   = n_hold[0];
            if (msg_t != MSG_PROGRAM && msg_t != MSG_CHAN_PRESS) begin
                n_res.second_data = n_hold[1];
            end
            if (msg_t == MSG_BEND) begin
                n_res.bend_value = {n_hold[1][6:0], n_hold[0][6:0]};
            end
        end
        if (emit_long) begin
            n_res.payload_length = n_len;
            priority if (n_status != ST_META) begin
                n_res.event_kind = KIND_SYSEX;
                n_res.first_data = n_status;
            end else if (n_meta == META_TEMPO) begin
                n_res.event_kind = KIND_TEMPO;
                n_res.first_data = n_meta;
                n_res.tempo_us   = n_tempo;
            end else if (n_meta == META_TIMESIG) begin
                n_res.event_kind                = KIND_TIMESIG;
                n_res.first_data                = n_hold[0];
                n_res.second_data               = n_hold[1];
                n_res.clocks_per_click          = n_hold[2];
                n_res.thirtyseconds_per_quarter = n_hold[3];
            end else if (n_meta == META_EOT) begin
                n_res.event_kind = KIND_EOT;
                n_res.first_data = n_meta;
            end else begin
                n_res.event_kind = KIND_META;
                n_res.first_data = n_meta;
            end
        end

        // Start the next event after a record
        if (emit_chan || emit_long) begin
            n_delta = '0;
            n_cnt   = '0;
            n_phase = (emit_long && n_status == ST_META && n_meta == META_EOT)
                      ? PH_DONE : PH_DELTA;
        end
    end

    assign emit    = emit_chan || emit_long;
    // Advance unless a record would land on a full, stalled result register
    assign advance = i_item.valid && !(emit && r_out_valid && i_stall);
    assign o_take  = advance;

    // Hold parse state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_delta     <= '0;
            r_cnt       <= '0;
            r_status    <= '0;
            r_skip      <= '0;
            r_meta      <= '0;
            r_tempo     <= '0;
            r_len       <= '0;
            for (int k = 0; k < 4; k++) r_hold[k] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase  <= n_phase;
                r_delta  <= n_delta;
                r_cnt    <= n_cnt;
                r_status <= n_status;
                r_skip   <= n_skip;
                r_meta   <= n_meta;
                r_tempo  <= n_tempo;
                r_len    <= n_len;
                for (int k = 0; k < 4; k++) r_hold[k] <= n_hold[k];
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
                r_res       <= n_res;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // Delta byte count stays within the quantity limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_DELTA_BYTES)
        else $error("delta byte count out of range");

    // A record never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled record overwritten");

    // After a record the delta time restarts from zero
    a_delta_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_delta == 28'd0 && r_cnt == 3'd0))
        else $error("delta not restarted after record");

    // End of track parks the parser
    a_eot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit && n_res.event_kind == KIND_EOT) |=> (r_phase == PH_DONE))
        else $error("end of track did not park parser");
`endif

endmodule

`default_nettype wire

// ----- rtl/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser.
// Instantiates mtep_in_reg and mtep_parser; uses mtep_pkg.
//
// Takes one byte of MIDI track chunk data per request and returns one record
// per complete event (channel message, SysEx, tempo, time signature, other
// meta, end of track) with its decoded delta time. A byte request is taken on
// every clock, so the sustained rate is one byte per cycle; the request of an
// event's last byte goes through the input register, its record through the
// result register. Only a stalled output with a record waiting and another
// record due holds the input side. Running status is not decoded; after end
// of track all bytes are dropped until a byte arrives with track start set.
`default_nettype none

module midi_track_event_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_track_byte,
    input  wire logic        i_track_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_kind,
    output logic [27:0]      o_delta_ticks,
    output logic [2:0]       o_message_type,
    output logic [3:0]       o_channel,
    output logic [7:0]       o_first_data,
    output logic [7:0]       o_second_data,
    output logic [13:0]      o_bend_value,
    output logic [23:0]      o_tempo_us,
    output logic [7:0]       o_payload_length,
    output logic [7:0]       o_clocks_per_click,
    output logic [7:0]       o_thirtyseconds_per_quarter
);
    import mtep_pkg::*;

    t_in_item item;
    t_result  res;
    logic     take;

    // Hold the incoming byte request
    mtep_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_track_byte  (i_track_byte),
        .i_track_start (i_track_start),
        .o_stall       (o_stall),
        .i_take        (take),
        .o_item        (item)
    );

    // Parse and register the record
    mtep_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .o_take   (take),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (res)
    );

    assign o_event_kind                = res.event_kind;
    assign o_delta_ticks               = res.delta_ticks;
    assign o_message_type              = res.message_type;
    assign o_channel                   = res.channel;
    assign o_first_data                = res.first_data;
    assign o_second_data               = res.second_data;
    assign o_bend_value                = res.bend_value;
    assign o_tempo_us                  = res.tempo_us;
    assign o_payload_length            = res.payload_length;
    assign o_clocks_per_click          = res.clocks_per_click;
    assign o_thirtyseconds_per_quarter = res.thirtyseconds_per_quarter;

endmodule

`default_nettype wire

// ----- dv/midi_track_event_parser_tb.sv -----
// Self-checking testbench for midi_track_event_parser: directed table, then random tracks.
// Depends on mtep_pkg, midi_track_event_parser, mtep_in_reg and mtep_parser in rtl/.
`timescale 1ns / 100ps

module midi_track_event_parser_tb;
    import mtep_pkg::*;

    // Parse position of the local track decoder
    typedef enum logic [3:0] {
        WAIT_DELTA,
        WAIT_STATUS,
        WAIT_DATA1,
        WAIT_DATA2,
        WAIT_META_TYPE,
        WAIT_LENGTH,
        SKIP_PAYLOAD,
        TRACK_ENDED
    } t_parse_step;

    typedef struct {
        logic [7:0] track_byte;
        logic       track_start;
        bit         typed;
        t_result    want;
    } t_stim_row;

    localparam int      RANDOM_BYTES = 1850;
    localparam t_result NO_REC       = '0;
    localparam t_result PROGRAM_REC  = '{KIND_CHANNEL, 28'd0, MSG_PROGRAM, 4'd5, 8'h7F,
                                         8'd0, 14'd0, 24'd0, 8'd0, 8'd0, 8'd0};
    localparam t_result BEND_REC     = '{KIND_CHANNEL, 28'h0FFFFFFF, MSG_BEND, 4'd0, 8'hFF,
                                         8'hFF, 14'h3FFF, 24'd0, 8'd0, 8'd0, 8'd0};
    localparam t_result SYSEX_REC    = '{KIND_SYSEX, 28'd0, 3'd0, 4'd0, ST_SYSEX_ESC,
                                         8'd0, 14'd0, 24'd0, 8'd0, 8'd0, 8'd0};
    localparam t_result EOT_REC      = '{KIND_EOT, 28'd0, 3'd0, 4'd0, META_EOT,
                                         8'd0, 14'd0, 24'd0, 8'd0, 8'd0, 8'd0};

    // Directed track: extremes, long delta, bad status, short tempo and time signature,
    // empty sysex, end of track and a byte ignored after it
    t_stim_row directed_rows [0:31] = '{
        '{8'h00, 1'b1, 1'b0, NO_REC},
        '{8'hC5, 1'b0, 1'b0, NO_REC},
        '{8'h7F, 1'b0, 1'b1, PROGRAM_REC},
        '{8'hFF, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b0, NO_REC},
        '{8'hE0, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b1, BEND_REC},
        '{8'h00, 1'b0, 1'b0, NO_REC},
        '{8'h40, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, NO_REC},
        '{ST_META, 1'b0, 1'b0, NO_REC},
        '{META_TEMPO, 1'b0, 1'b0, NO_REC},
        '{8'h02, 1'b0, 1'b0, NO_REC},
        '{8'hAB, 1'b0, 1'b0, NO_REC},
        '{8'hCD, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, NO_REC},
        '{ST_META, 1'b0, 1'b0, NO_REC},
        '{META_TIMESIG, 1'b0, 1'b0, NO_REC},
        '{8'h02, 1'b0, 1'b0, NO_REC},
        '{8'h04, 1'b0, 1'b0, NO_REC},
        '{8'h02, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, NO_REC},
        '{ST_SYSEX_ESC, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, SYSEX_REC},
        '{8'h00, 1'b0, 1'b0, NO_REC},
        '{ST_META, 1'b0, 1'b0, NO_REC},
        '{META_EOT, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, EOT_REC},
        '{8'h90, 1'b0, 1'b0, NO_REC}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_track_byte  = 8'd0;
    logic        i_track_start = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [27:0] o_delta_ticks;
    logic [2:0]  o_message_type;
    logic [3:0]  o_channel;
    logic [7:0]  o_first_data;
    logic [7:0]  o_second_data;
    logic [13:0] o_bend_value;
    logic [23:0] o_tempo_us;
    logic [7:0]  o_payload_length;
    logic [7:0]  o_clocks_per_click;
    logic [7:0]  o_thirtyseconds_per_quarter;

    // Local copy of the parse state
    t_parse_step phase;
    logic [27:0] delta_sum;
    logic [2:0]  delta_len;
    logic [7:0]  status_byte;
    logic [7:0]  held_data [4];
    logic [7:0]  bytes_left;
    logic [7:0]  meta_type;
    logic [23:0] tempo_sum;
    logic [7:0]  length_byte;

    t_result pending_events [$];
    int      fail_count  = 0;
    int      bytes_used  = 0;
    int      event_count = 0;
    int      kind_seen [6];
    int      stall_left  = 0;
    bit      quiet_phase = 1'b0;
    bit      need_start  = 1'b1;

    midi_track_event_parser dut (
        .i_clk                       (i_clk),
        .i_rst_n                     (i_rst_n),
        .i_valid                     (i_valid),
        .o_stall                     (o_stall),
        .i_track_byte                (i_track_byte),
        .i_track_start               (i_track_start),
        .o_valid                     (o_valid),
        .i_stall                     (i_stall),
        .o_event_kind                (o_event_kind),
        .o_delta_ticks               (o_delta_ticks),
        .o_message_type              (o_message_type),
        .o_channel                   (o_channel),
        .o_first_data                (o_first_data),
        .o_second_data               (o_second_data),
        .o_bend_value                (o_bend_value),
        .o_tempo_us                  (o_tempo_us),
        .o_payload_length            (o_payload_length),
        .o_clocks_per_click          (o_clocks_per_click),
        .o_thirtyseconds_per_quarter (o_thirtyseconds_per_quarter)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop for a hung run
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Track decoder
    // ------------------------------------------------------------------
    function automatic void clear_parse_state();
        phase       = WAIT_DELTA;
        delta_sum   = '0;
        delta_len   = '0;
        status_byte = '0;
        held_data   = '{default: '0};
        bytes_left  = '0;
        meta_type   = '0;
        tempo_sum   = '0;
        length_byte = '0;
    endfunction

    function automatic void start_next_event();
        delta_sum = '0;
        delta_len = '0;
        phase     = WAIT_DELTA;
    endfunction

    function automatic t_result channel_record();
        t_result     r;
        logic [2:0]  mtype;
        r     = '0;
        mtype = status_byte[6:4];
        r.event_kind   = KIND_CHANNEL;
        r.delta_ticks  = delta_sum;
        r.message_type = mtype;
        r.channel      = status_byte[3:0];
        r.first_data   = held_data[0];
        if (mtype != MSG_PROGRAM && mtype != MSG_CHAN_PRESS)
            r.second_data = held_data[1];
        if (mtype == MSG_BEND)
            r.bend_value = {held_data[1][6:0], held_data[0][6:0]};
        start_next_event();
        return r;
    endfunction

    function automatic t_result sysex_meta_record();
        t_result r;
        bit      ended;
        r     = '0;
        ended = 1'b0;
        r.delta_ticks    = delta_sum;
        r.payload_length = length_byte;
        if (status_byte != ST_META) begin
            r.event_kind = KIND_SYSEX;
            r.first_data = status_byte;
        end else if (meta_type == META_TEMPO) begin
            r.event_kind = KIND_TEMPO;
            r.first_data = meta_type;
            r.tempo_us   = tempo_sum;
        end else if (meta_type == META_TIMESIG) begin
            r.event_kind                = KIND_TIMESIG;
            r.first_data                = held_data[0];
            r.second_data               = held_data[1];
            r.clocks_per_click          = held_data[2];
            r.thirtyseconds_per_quarter = held_data[3];
        end else if (meta_type == META_EOT) begin
            r.event_kind = KIND_EOT;
            r.first_data = meta_type;
            ended        = 1'b1;
        end else begin
            r.event_kind = KIND_META;
            r.first_data = meta_type;
        end
        start_next_event();
        if (ended)
            phase = TRACK_ENDED;
        return r;
    endfunction

    // Advance the decoder by one track byte; return 1 when an event record completes
    function automatic bit parse_track_byte(input logic [7:0] b, input logic s,
                                            output t_result rec);
        bit         emitted;
        logic [7:0] idx;
        emitted = 1'b0;
        rec     = '0;
        if (s)
            clear_parse_state();
        case (phase)
            WAIT_DELTA: begin
                delta_sum = {delta_sum[20:0], b[6:0]};
                delta_len = delta_len + 3'd1;
                if (!b[7] || delta_len >= MAX_DELTA_BYTES)
                    phase = WAIT_STATUS;
            end
            WAIT_STATUS: begin
                held_data   = '{default: '0};
                tempo_sum   = '0;
                meta_type   = '0;
                length_byte = '0;
                bytes_left  = '0;
                if (b >= ST_CHAN_LO && b <= ST_CHAN_HI) begin
                    status_byte = b;
                    phase       = WAIT_DATA1;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    status_byte = b;
                    phase       = WAIT_LENGTH;
                end else if (b == ST_META) begin
                    status_byte = b;
                    phase       = WAIT_META_TYPE;
                end else begin
                    start_next_event();
                end
            end
            WAIT_DATA1: begin
                held_data[0] = b;
                if (status_byte[6:4] == MSG_PROGRAM || status_byte[6:4] == MSG_CHAN_PRESS) begin
                    rec     = channel_record();
                    emitted = 1'b1;
                end else begin
                    phase = WAIT_DATA2;
                end
            end
            WAIT_DATA2: begin
                held_data[1] = b;
                rec          = channel_record();
                emitted      = 1'b1;
            end
            WAIT_META_TYPE: begin
                meta_type = b;
                phase     = WAIT_LENGTH;
            end
            WAIT_LENGTH: begin
                length_byte = b;
                bytes_left  = b;
                if (b == 8'd0) begin
                    rec     = sysex_meta_record();
                    emitted = 1'b1;
                end else begin
                    phase = SKIP_PAYLOAD;
                end
            end
            SKIP_PAYLOAD: begin
                idx = length_byte - bytes_left;
                if (status_byte == ST_META && meta_type == META_TEMPO && idx < 8'd3)
                    tempo_sum = {tempo_sum[15:0], b};
                if (status_byte == ST_META && meta_type == META_TIMESIG && idx < 8'd4)
                    held_data[idx[1:0]] = b;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    rec     = sysex_meta_record();
                    emitted = 1'b1;
                end
            end
            default: ;
        endcase
        return emitted;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly no gap, some short ones, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic int payload_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 8);
        else if (r < 98)
            return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    // Present one request, hold it until taken, then record what it should produce
    task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                             input t_result want);
        int      gap;
        t_result rec;
        gap = quiet_phase ? 0 : idle_len();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_track_byte  <= b;
        i_track_start <= s;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (s || phase != TRACK_ENDED)
            bytes_used++;
        if (parse_track_byte(b, s, rec) && !typed)
            pending_events.push_back(rec);
        if (typed)
            pending_events.push_back(want);
    endtask

    task automatic send_length_and_payload(input int len);
        send_byte(8'(len), 1'b0, 1'b0, NO_REC);
        for (int i = 0; i < len; i++)
            send_byte(data_byte(), 1'b0, 1'b0, NO_REC);
    endtask

    // One event with random content; now and then a bad status or a broken fragment
    task automatic send_random_event();
        int         n;
        int         pick;
        int         r;
        bit         first_start;
        logic [7:0] b;
        logic [7:0] mtype;
        first_start = need_start || ($urandom_range(0, 49) == 0);
        need_start  = 1'b0;

        // delta time, mostly one byte
        r = $urandom_range(0, 99);
        n = (r < 70) ? 1 : (r < 85) ? 2 : (r < 93) ? 3 : 4;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (i < n - 1)
                b[7] = 1'b1;
            else if (n < 4)
                b[7] = 1'b0;
            send_byte(b, first_start && i == 0, 1'b0, NO_REC);
        end

        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            b = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            send_byte(b, 1'b0, 1'b0, NO_REC);
            send_byte(data_byte(), 1'b0, 1'b0, NO_REC);
            if (b[6:4] != MSG_PROGRAM && b[6:4] != MSG_CHAN_PRESS)
                send_byte(data_byte(), 1'b0, 1'b0, NO_REC);
        end else if (pick < 65) begin
            send_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC, 1'b0, 1'b0, NO_REC);
            send_length_and_payload(payload_len());
        end else if (pick < 93) begin
            r = $urandom_range(0, 99);
            mtype = (r < 30) ? META_TEMPO : (r < 55) ? META_TIMESIG :
                    (r < 62) ? META_EOT : 8'($urandom);
            send_byte(ST_META, 1'b0, 1'b0, NO_REC);
            send_byte(mtype, 1'b0, 1'b0, NO_REC);
            r = $urandom_range(0, 99);
            if (mtype == META_TEMPO && r < 70)
                send_length_and_payload(3);
            else if (mtype == META_TIMESIG && r < 70)
                send_length_and_payload(4);
            else if (mtype == META_EOT && r < 80)
                send_length_and_payload(0);
            else
                send_length_and_payload(payload_len());
            if (mtype == META_EOT)
                need_start = 1'b1;
        end else if (pick < 97) begin
            do
                b = 8'($urandom);
            while ((b >= ST_CHAN_LO && b <= ST_CHAN_HI) || b == ST_SYSEX ||
                   b == ST_SYSEX_ESC || b == ST_META);
            send_byte(b, 1'b0, 1'b0, NO_REC);
        end else begin
            // broken fragment, cut off by a new track
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), 1'b0, 1'b0, NO_REC);
            need_start = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall generator
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet_phase)
                stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Record checker
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [27:0] got,
                               input logic [27:0] want);
        if (got !== want)
            note_failure($sformatf("field %s: want %0h, got %0h", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_event_kind, o_delta_ticks, o_message_type, o_channel, o_first_data,
                    o_second_data, o_bend_value, o_tempo_us, o_payload_length,
                    o_clocks_per_click, o_thirtyseconds_per_quarter};
            if (pending_events.size() == 0) begin
                note_failure($sformatf("unrequested record, kind %0d delta %0h",
                                       got.event_kind, got.delta_ticks));
            end else begin
                want = pending_events.pop_front();
                if (want.event_kind < 3'd6)
                    kind_seen[want.event_kind]++;
                check_field("event_kind", 28'(got.event_kind), 28'(want.event_kind));
                check_field("delta_ticks", got.delta_ticks, want.delta_ticks);
                check_field("message_type", 28'(got.message_type), 28'(want.message_type));
                check_field("channel", 28'(got.channel), 28'(want.channel));
                check_field("first_data", 28'(got.first_data), 28'(want.first_data));
                check_field("second_data", 28'(got.second_data), 28'(want.second_data));
                check_field("bend_value", 28'(got.bend_value), 28'(want.bend_value));
                check_field("tempo_us", 28'(got.tempo_us), 28'(want.tempo_us));
                check_field("payload_length", 28'(got.payload_length),
                            28'(want.payload_length));
                check_field("clocks_per_click", 28'(got.clocks_per_click),
                            28'(want.clocks_per_click));
                check_field("thirtyseconds_per_quarter", 28'(got.thirtyseconds_per_quarter),
                            28'(want.thirtyseconds_per_quarter));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parse_state();
        kind_seen = '{default: 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int i = 0; i < 32; i++)
            send_byte(directed_rows[i].track_byte, directed_rows[i].track_start,
                      directed_rows[i].typed, directed_rows[i].want);

        // random tracks, with stretches of back-to-back traffic
        need_start = 1'b1;
        bytes_used = 0;
        while (bytes_used < RANDOM_BYTES) begin
            quiet_phase = ((event_count / 100) % 4 == 3);
            send_random_event();
            event_count++;
        end
        quiet_phase = 1'b0;
        i_valid <= 1'b0;

        // drain and let the pipeline settle
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d counted track bytes in %0d random events after the directed table.",
                 bytes_used, event_count);
        $display("Records: channel %0d, sysex %0d, meta %0d, tempo %0d, time sig %0d, eot %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
